[hw/rtl/sliding_window_duration_stats_defines.svh]
// Assertion macros shared by the window statistics RTL.
`ifndef SLIDING_WINDOW_DURATION_STATS_DEFINES_SVH
`define SLIDING_WINDOW_DURATION_STATS_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define SWDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define SWDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/swds_pkg.sv]
package swds_pkg;

  localparam int unsigned FIELD_BITS = 40;
  localparam int unsigned COUNT_FIELD_BITS = 9;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic latch;
    logic update;
    logic start;
    logic scan;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/swds_if.sv]
interface swds_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [swds_pkg::FIELD_BITS-1:0] sample_ns;

  modport source (output valid, op, sample_ns, input ready);
  modport sink   (input valid, op, sample_ns, output ready);
endinterface

interface swds_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [swds_pkg::FIELD_BITS-1:0]       latest_ns;
  logic [swds_pkg::FIELD_BITS-1:0]       min_ns;
  logic [swds_pkg::FIELD_BITS-1:0]       max_ns;
  logic [swds_pkg::FIELD_BITS-1:0]       avg_ns;
  logic [swds_pkg::COUNT_FIELD_BITS-1:0] sample_count;

  modport source (output valid, latest_ns, min_ns, max_ns, avg_ns, sample_count,
                  input ready);
  modport sink   (input valid, latest_ns, min_ns, max_ns, avg_ns, sample_count,
                  output ready);
endinterface

[hw/rtl/swds_ctrl.sv]
`include "sliding_window_duration_stats_defines.svh"

module swds_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  swds_pkg::status_t st_i,
  output swds_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DIVI   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_START;
      end
      S_START: begin
        cmd_o.start = 1'b1;
        // an empty window reports zeros straight away
        state_d     = st_i.empty ? S_FIN : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.scan_done) begin
          state_d = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        if (st_i.div_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SWDS_ASSERT_IMP(a_load_needs_room, cmd_o.load_out, st_i.out_free, "result overwritten")
  `SWDS_ASSERT_NXT(a_accept_starts, cmd_o.latch, state_q == S_UPDATE, "accept lost")

endmodule

[hw/rtl/swds_dp.sv]
`include "sliding_window_duration_stats_defines.svh"

module swds_dp #(
  parameter int unsigned WINDOW_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS  = 40
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  swds_pkg::cmd_t                        cmd_i,
  output swds_pkg::status_t                     st_o,
  input  logic                                  in_op_i,
  input  logic [swds_pkg::FIELD_BITS-1:0]       in_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [swds_pkg::FIELD_BITS-1:0]       out_latest_o,
  output logic [swds_pkg::FIELD_BITS-1:0]       out_min_o,
  output logic [swds_pkg::FIELD_BITS-1:0]       out_max_o,
  output logic [swds_pkg::FIELD_BITS-1:0]       out_avg_o,
  output logic [swds_pkg::COUNT_FIELD_BITS-1:0] out_count_o
);

  localparam int unsigned FB       = swds_pkg::FIELD_BITS;
  localparam int unsigned CFB      = swds_pkg::COUNT_FIELD_BITS;
  localparam int unsigned AW       = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PW       = CNT_BITS + 1;
  localparam int unsigned SUM_BITS = SAMPLE_BITS + CNT_BITS;
  localparam int unsigned DCW      = $clog2(SUM_BITS + 1);
  localparam int unsigned XW       = SAMPLE_BITS + FB;

  localparam logic [AW-1:0]       LAST_SLOT = AW'(WINDOW_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(WINDOW_DEPTH);
  localparam logic [PW-1:0]       DEPTH_PW  = PW'(WINDOW_DEPTH);
  localparam logic [XW-1:0]       SAT_LIMIT = {{FB{1'b0}}, {SAMPLE_BITS{1'b1}}};

  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_q;

  logic                   op_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [AW-1:0]          oldest_q;
  logic [CNT_BITS-1:0]    cnt_q;
  logic [AW-1:0]          ptr_q;
  logic [CNT_BITS-1:0]    remain_q;
  logic                   rd_valid_q;
  logic [SAMPLE_BITS-1:0] min_q, max_q, latest_q;
  logic [SUM_BITS-1:0]    sum_q;
  logic [CNT_BITS-1:0]    rem_q;
  logic [SUM_BITS-1:0]    quo_q;
  logic [DCW-1:0]         div_cnt_q;
  logic                   out_valid_q;
  logic [FB-1:0]          latest_out_q, min_out_q, max_out_q, avg_out_q;
  logic [CFB-1:0]         count_out_q;

  logic [XW-1:0]          in_ext;
  logic [SAMPLE_BITS-1:0] in_sat;
  logic                   full;
  logic [PW-1:0]          pos_sum;
  logic [AW-1:0]          wr_pos;
  logic [AW-1:0]          ptr_next;
  logic [AW-1:0]          oldest_next;
  logic                   ring_we;
  logic [AW-1:0]          ring_waddr;
  logic [PW-1:0]          rem_sh;
  logic                   rem_ge;
  logic [XW-1:0]          latest_ext, min_ext, max_ext;
  logic [SUM_BITS+FB-1:0] quo_ext;
  logic [CNT_BITS+CFB-1:0] cnt_ext;

  // saturate oversized samples to the stored width
  assign in_ext = {{SAMPLE_BITS{1'b0}}, in_sample_i};
  assign in_sat = (in_ext > SAT_LIMIT) ? {SAMPLE_BITS{1'b1}} : in_ext[SAMPLE_BITS-1:0];

  assign full    = (cnt_q == FULL_CNT);
  assign pos_sum = PW'(oldest_q) + PW'(cnt_q);
  assign wr_pos  = (pos_sum >= DEPTH_PW) ? AW'(pos_sum - DEPTH_PW) : AW'(pos_sum);

  assign ptr_next    = (ptr_q == LAST_SLOT) ? '0 : ptr_q + AW'(1);
  assign oldest_next = (oldest_q == LAST_SLOT) ? '0 : oldest_q + AW'(1);

  assign ring_we    = cmd_i.update && (op_q == swds_pkg::OP_PUSH);
  assign ring_waddr = full ? oldest_q : wr_pos;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= smp_q;
    end
    rd_data_q <= ring_mem[ptr_q];
  end

  assign rem_sh = {rem_q, quo_q[SUM_BITS-1]};
  assign rem_ge = (rem_sh >= PW'(cnt_q));

  // window state and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      remain_q    <= '0;
      rd_valid_q  <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        if (op_q == swds_pkg::OP_CLEAR) begin
          oldest_q <= '0;
          cnt_q    <= '0;
        end else if (full) begin
          oldest_q <= oldest_next;
        end else begin
          cnt_q <= cnt_q + CNT_BITS'(1);
        end
      end

      if (cmd_i.start) begin
        ptr_q      <= oldest_q;
        remain_q   <= cnt_q;
        rd_valid_q <= 1'b0;
      end else if (cmd_i.scan) begin
        if (remain_q != '0) begin
          ptr_q      <= ptr_next;
          remain_q   <= remain_q - CNT_BITS'(1);
          rd_valid_q <= 1'b1;
        end else begin
          rd_valid_q <= 1'b0;
        end
      end

      if (cmd_i.div_init) begin
        div_cnt_q <= DCW'(SUM_BITS);
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q - DCW'(1);
      end

      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: input capture, running min/max/sum, restoring divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= in_op_i;
      smp_q <= in_sat;
    end
    if (cmd_i.start) begin
      min_q    <= '1;
      max_q    <= '0;
      latest_q <= '0;
      sum_q    <= '0;
    end else if (cmd_i.scan && rd_valid_q) begin
      if (rd_data_q < min_q) min_q <= rd_data_q;
      if (rd_data_q > max_q) max_q <= rd_data_q;
      latest_q <= rd_data_q;
      sum_q    <= sum_q + SUM_BITS'(rd_data_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= sum_q;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? CNT_BITS'(rem_sh - PW'(cnt_q)) : CNT_BITS'(rem_sh);
      quo_q <= {quo_q[SUM_BITS-2:0], rem_ge};
    end
  end

  assign latest_ext = {{FB{1'b0}}, latest_q};
  assign min_ext    = {{FB{1'b0}}, min_q};
  assign max_ext    = {{FB{1'b0}}, max_q};
  assign quo_ext    = {{FB{1'b0}}, quo_q};
  assign cnt_ext    = {{CFB{1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (cnt_q == '0) begin
        latest_out_q <= '0;
        min_out_q    <= '0;
        max_out_q    <= '0;
        avg_out_q    <= '0;
      end else begin
        latest_out_q <= latest_ext[FB-1:0];
        min_out_q    <= min_ext[FB-1:0];
        max_out_q    <= max_ext[FB-1:0];
        avg_out_q    <= quo_ext[FB-1:0];
      end
      count_out_q <= cnt_ext[CFB-1:0];
    end
  end

  assign st_o.empty     = (cnt_q == '0);
  assign st_o.scan_done = (remain_q == '0) && !rd_valid_q;
  assign st_o.div_done  = (div_cnt_q == '0);
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_latest_o = latest_out_q;
  assign out_min_o    = min_out_q;
  assign out_max_o    = max_out_q;
  assign out_avg_o    = avg_out_q;
  assign out_count_o  = count_out_q;

  `SWDS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= FULL_CNT, "window count above depth")
  `SWDS_ASSERT_IMP(a_oldest_full, cnt_q != FULL_CNT, oldest_q == '0, "ring start moved early")
  `SWDS_ASSERT_NXT(a_load_valid, cmd_i.load_out, out_valid_q, "loaded result not shown")

endmodule

[hw/rtl/sliding_window_duration_stats.sv]
// Steps: a transaction is latched, updates the window, starts the scan, scans the N samples
// in the window (N being the fill after the push) and divides the sum bit-serially over
// SUM_BITS = SAMPLE_BITS + clog2(WINDOW_DEPTH + 1) quotient bits before the result is loaded;
// a clear (empty window) skips the scan and divide. Only one transaction is in flight;
// ready returns as the result is loaded, so the busy time is set by the ring scan (one memory
// read per cycle) and the bit-serial divider. A result held back by the sink stalls the input.
// Reset clears the window (count and ring start) at once; the ring memory is not cleared.
module sliding_window_duration_stats #(
  parameter int unsigned WINDOW_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS  = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  swds_in_if.sink           in_i,
  swds_out_if.source        out_o
);

  swds_pkg::cmd_t    cmd;
  swds_pkg::status_t st;

  swds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  swds_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .in_op_i      (in_i.op),
    .in_sample_i  (in_i.sample_ns),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_latest_o (out_o.latest_ns),
    .out_min_o    (out_o.min_ns),
    .out_max_o    (out_o.max_ns),
    .out_avg_o    (out_o.avg_ns),
    .out_count_o  (out_o.sample_count)
  );

endmodule

[verif/sliding_window_duration_stats_test.sv]
module sliding_window_duration_stats_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_BITS       = swds_pkg::FIELD_BITS;
  localparam int unsigned COUNT_FIELD_BITS = swds_pkg::COUNT_FIELD_BITS;

  localparam int unsigned RING_DEPTH  = 256;
  localparam logic [FIELD_BITS-1:0] DURATION_MAX = '1;
  localparam int unsigned RANDOM_ITEMS = 635;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam realtime RUN_LIMIT = 4_000_000ns;

  typedef struct packed {
    logic                  op;
    logic [FIELD_BITS-1:0] sample;
    logic                  drain;   // hold until every outstanding result is back
  } duration_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0]       latest;
    logic [FIELD_BITS-1:0]       lo;
    logic [FIELD_BITS-1:0]       hi;
    logic [FIELD_BITS-1:0]       mean;
    logic [COUNT_FIELD_BITS-1:0] fill;
  } window_stats_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  swds_in_if  in_if ();
  swds_out_if out_if ();

  sliding_window_duration_stats u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the window state
  logic [FIELD_BITS-1:0]       shadow_ring [RING_DEPTH];
  logic [7:0]                  shadow_oldest;
  logic [COUNT_FIELD_BITS-1:0] shadow_fill;
  logic [47:0]                 shadow_total;

  duration_item_t duration_q [$];
  window_stats_t  stats_q [$];

  duration_item_t cur_item;
  bit  send_active, send_burst, in_accepted;
  int  send_gap;
  bit  recv_burst, out_accepted;
  int  recv_stall;
  int  mismatch_count;
  int  fail_count;

  task automatic window_update(input logic op, input logic [FIELD_BITS-1:0] smp,
                               output window_stats_t res);
    logic [7:0]            slot;
    logic [FIELD_BITS-1:0] v;
    res = '0;
    if (op == swds_pkg::OP_CLEAR) begin
      shadow_oldest = '0;
      shadow_fill   = '0;
      shadow_total  = '0;
    end else begin
      // Sample width equals field width, so saturation never bites here
      if (shadow_fill == COUNT_FIELD_BITS'(RING_DEPTH)) begin
        shadow_total -= 48'(shadow_ring[shadow_oldest]);
        shadow_ring[shadow_oldest] = smp;
        shadow_oldest = shadow_oldest + 8'd1;
      end else begin
        slot = shadow_oldest + shadow_fill[7:0];
        shadow_ring[slot] = smp;
        shadow_fill = shadow_fill + 1'b1;
      end
      shadow_total += 48'(smp);
    end
    if (shadow_fill != 0) begin
      slot = shadow_oldest + 8'(shadow_fill - 1'b1);
      res.latest = shadow_ring[slot];
      res.lo = shadow_ring[shadow_oldest];
      res.hi = res.lo;
      for (int i = 1; i < int'(shadow_fill); i++) begin
        slot = shadow_oldest + 8'(i);
        v = shadow_ring[slot];
        if (v < res.lo) res.lo = v;
        if (v > res.hi) res.hi = v;
      end
      res.mean = FIELD_BITS'(shadow_total / 48'(shadow_fill));
    end
    res.fill = shadow_fill;
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_duration();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return DURATION_MAX;
      2:       return FIELD_BITS'($urandom_range(0, 1000));
      3:       return DURATION_MAX - FIELD_BITS'($urandom_range(0, 1000));
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic void add_item(input logic op, input logic [FIELD_BITS-1:0] smp,
                                   input logic drain);
    duration_item_t it;
    it.op = op;
    it.sample = smp;
    it.drain = drain;
    duration_q.push_back(it);
  endfunction

  // Sender: present one transaction at a time, with a drawn gap between them
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_accepted) begin
        in_accepted = 1'b0;
        send_active = 1'b0;
      end
      if (!send_active) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (duration_q.size() != 0 &&
                     !(duration_q[0].drain && stats_q.size() != 0)) begin
          cur_item = duration_q[0];
          duration_q.delete(0);
          send_active = 1'b1;
          if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 7);
        end
      end
      in_if.valid     <= send_active;
      in_if.op        <= send_active ? cur_item.op : 1'($urandom_range(0, 1));
      in_if.sample_ns <= send_active ? cur_item.sample : {8'($urandom), 32'($urandom)};
    end
  end

  // Receiver: stall drawn per result, counted down mostly while a result waits
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_accepted) begin
        out_accepted = 1'b0;
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 7);
      end
      if (recv_stall != 0 && (out_if.valid || $urandom_range(0, 1) == 1)) recv_stall--;
      out_if.ready <= (recv_stall == 0);
    end
  end

  // Monitor: predict on each accepted sample, check each accepted result
  always @(posedge clk_i) begin
    window_stats_t want, got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        in_accepted = 1'b1;
        window_update(in_if.op, in_if.sample_ns, want);
        stats_q.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        out_accepted = 1'b1;
        got.latest = out_if.latest_ns;
        got.lo     = out_if.min_ns;
        got.hi     = out_if.max_ns;
        got.mean   = out_if.avg_ns;
        got.fill   = out_if.sample_count;
        if (stats_q.size() == 0) begin
          fail_count++;
          if (mismatch_count < 10)
            $display("%t: result with nothing outstanding: latest %h min %h max %h avg %h n %0d",
                     $realtime, got.latest, got.lo, got.hi, got.mean, got.fill);
          mismatch_count++;
        end else begin
          want = stats_q[0];
          stats_q.delete(0);
          if (got.latest !== want.latest || got.lo !== want.lo || got.hi !== want.hi ||
              got.mean !== want.mean || got.fill !== want.fill) begin
            fail_count++;
            if (mismatch_count < 10) begin
              $display("%t: stats mismatch", $realtime);
              $display("  exp: latest %h min %h max %h avg %h n %0d",
                       want.latest, want.lo, want.hi, want.mean, want.fill);
              $display("  got: latest %h min %h max %h avg %h n %0d",
                       got.latest, got.lo, got.hi, got.mean, got.fill);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    int n_random;
    int seg;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.op         = swds_pkg::OP_PUSH;
    in_if.sample_ns  = '0;
    out_if.ready     = 1'b0;
    shadow_oldest    = '0;
    shadow_fill      = '0;
    shadow_total     = '0;
    send_active      = 1'b0;
    send_burst       = 1'b0;
    send_gap         = 0;
    in_accepted      = 1'b0;
    recv_burst       = 1'b0;
    recv_stall       = 0;
    out_accepted     = 1'b0;
    mismatch_count   = 0;
    fail_count       = 0;

    // Directed: empty window, extremes, alternating bits, clears
    add_item(swds_pkg::OP_CLEAR, '0, 1'b0);
    add_item(swds_pkg::OP_PUSH, '0, 1'b0);
    add_item(swds_pkg::OP_PUSH, DURATION_MAX, 1'b0);
    add_item(swds_pkg::OP_PUSH, 40'd1, 1'b0);
    add_item(swds_pkg::OP_PUSH, DURATION_MAX - 1'b1, 1'b0);
    add_item(swds_pkg::OP_PUSH, 40'h55_5555_5555, 1'b0);
    add_item(swds_pkg::OP_PUSH, 40'hAA_AAAA_AAAA, 1'b0);
    add_item(swds_pkg::OP_CLEAR, DURATION_MAX, 1'b0);
    add_item(swds_pkg::OP_PUSH, DURATION_MAX, 1'b0);
    add_item(swds_pkg::OP_PUSH, DURATION_MAX, 1'b0);
    add_item(swds_pkg::OP_CLEAR, '0, 1'b0);
    add_item(swds_pkg::OP_CLEAR, '0, 1'b0);
    add_item(swds_pkg::OP_PUSH, '0, 1'b1);
    add_item(swds_pkg::OP_PUSH, 40'd7, 1'b0);
    add_item(swds_pkg::OP_PUSH, 40'h80_0000_0000, 1'b0);

    // Fill past the window so the oldest samples get evicted
    for (int i = 0; i < 290; i++) add_item(swds_pkg::OP_PUSH, pick_duration(), i == 0);
    add_item(swds_pkg::OP_CLEAR, pick_duration(), 1'b0);
    n_random = 291;
    while (n_random < int'(RANDOM_ITEMS)) begin
      seg = ($urandom_range(0, 5) == 0) ? $urandom_range(150, 270) : $urandom_range(0, 30);
      if (seg > int'(RANDOM_ITEMS) - n_random - 1) seg = int'(RANDOM_ITEMS) - n_random - 1;
      for (int i = 0; i < seg; i++)
        add_item(swds_pkg::OP_PUSH, pick_duration(), $urandom_range(0, 49) == 0);
      add_item(swds_pkg::OP_CLEAR, pick_duration(), 1'b0);
      n_random += seg + 1;
      if (n_random < int'(RANDOM_ITEMS) && $urandom_range(0, 3) == 0) begin
        add_item(swds_pkg::OP_CLEAR, pick_duration(), 1'b0);
        n_random++;
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (duration_q.size() != 0 || send_active) @(posedge clk_i);
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("** sliding_window_duration_stats: PASSED **");
    end else begin
      $display("** sliding_window_duration_stats: FAILED **");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("%t: run limit reached, %0d results outstanding", $realtime, stats_q.size());
    $display("** sliding_window_duration_stats: FAILED **");
    $finish;
  end

endmodule

[sliding_window_duration_stats.f]
+incdir+hw/rtl
hw/rtl/swds_pkg.sv
hw/rtl/swds_if.sv
hw/rtl/swds_ctrl.sv
hw/rtl/swds_dp.sv
hw/rtl/sliding_window_duration_stats.sv
verif/sliding_window_duration_stats_test.sv
